### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lbl failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbl failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES_DEF = 4096;
  localparam int HDR_BYTES      = 2;
  localparam int HDR_W          = 16;
  localparam int SIZE_W         = 15;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_REDUNDANT = 3'd3;
  localparam logic [2:0] ST_BAD_PTR   = 3'd4;

  typedef struct packed {
    logic       init_wr;
    logic       load;
    logic       rd_off;
    logic       rd_nxt;
    logic       walk_step;
    logic       wr_whole;
    logic       wr_low;
    logic       wr_high;
    logic       wr_clear;
    logic       zero_off;
    logic       m_latch;
    logic       m_merge;
    logic       m_shift;
    logic       set_st;
    logic [2:0] st_code;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_size;
    logic fit;
    logic split;
    logic ptr_hit;
    logic used;
    logic walk_end;
    logic both_free;
    logic merged_end;
    logic shift_end;
    logic out_busy;
  } dp_stat_t;

endpackage

### sv/ffha_dp.sv
// Datapath: header memory, walk pointers and result register.
module ffha_dp import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_cmd,
  input  logic [15:0] in_req,
  input  logic [11:0] in_ptr,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [11:0] out_offset,
  output logic [2:0]  out_status
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam logic [16:0] HEAP17 = 17'(HEAP_BYTES);
  localparam logic [15:0] MAX_REQ = 16'(HEAP_BYTES - HDR_BYTES);
  localparam logic [16:0] HDR17 = 17'(HDR_BYTES);

  logic [HDR_W-1:0] mem [HEAP_BYTES];
  logic [HDR_W-1:0] rd_data;
  logic [AW-1:0]    off, nxt, split_addr;
  logic [HDR_W-1:0] cur_hdr;
  logic [15:0]      req;
  logic [11:0]      ptr;
  logic             is_free;
  logic [11:0]      res;
  logic [2:0]       st;

  logic [16:0]       next_walk, next_merged, next_shift, off_plus;
  logic [SIZE_W-1:0] low_size, merged_size;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [HDR_W-1:0]  wr_data;

  assign off_plus    = 17'(off) + HDR17;
  assign next_walk   = off_plus + 17'(rd_data[SIZE_W-1:0]);
  assign merged_size = SIZE_W'(17'(cur_hdr[SIZE_W-1:0]) + HDR17 + 17'(rd_data[SIZE_W-1:0]));
  assign next_merged = off_plus + 17'(merged_size);
  assign next_shift  = 17'(nxt) + HDR17 + 17'(rd_data[SIZE_W-1:0]);
  assign low_size    = SIZE_W'(17'(rd_data[SIZE_W-1:0]) - 17'(req) - HDR17);

  always_comb begin
    stat.is_free    = is_free;
    stat.bad_size   = (in_req == 16'd0) || (in_req > MAX_REQ);
    stat.fit        = !rd_data[HDR_W-1] && (16'(rd_data[SIZE_W-1:0]) >= req);
    stat.split      = (17'(rd_data[SIZE_W-1:0]) - 17'(req)) > HDR17;
    stat.ptr_hit    = off_plus == 17'(ptr);
    stat.used       = rd_data[HDR_W-1];
    stat.walk_end   = next_walk >= HEAP17;
    stat.both_free  = !cur_hdr[HDR_W-1] && !rd_data[HDR_W-1];
    stat.merged_end = next_merged >= HEAP17;
    stat.shift_end  = next_shift >= HEAP17;
    stat.out_busy   = out_valid && !out_ready;
  end

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = off;
    wr_data = rd_data;
    if (cmd.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = HDR_W'(HEAP_BYTES - HDR_BYTES);
    end else if (cmd.wr_whole) begin
      wr_en   = 1'b1;
      wr_data = {1'b1, rd_data[SIZE_W-1:0]};
    end else if (cmd.wr_low) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, low_size};
    end else if (cmd.wr_high) begin
      wr_en   = 1'b1;
      wr_addr = split_addr;
      wr_data = {1'b1, req[SIZE_W-1:0]};
    end else if (cmd.wr_clear) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, rd_data[SIZE_W-1:0]};
    end else if (cmd.m_merge) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, merged_size};
    end
  end

  assign rd_addr = cmd.rd_nxt ? nxt : off;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_off || cmd.rd_nxt) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= in_req;
      ptr     <= in_ptr;
      is_free <= in_cmd == CMD_FREE;
      off     <= '0;
      res     <= '0;
    end
    if (cmd.walk_step) begin
      off <= AW'(next_walk);
    end
    if (cmd.zero_off) begin
      off <= '0;
    end
    if (cmd.wr_whole) begin
      res <= off_plus[11:0];
    end
    if (cmd.wr_low) begin
      split_addr <= AW'(off_plus + 17'(low_size));
    end
    if (cmd.wr_high) begin
      res <= 12'(17'(split_addr) + HDR17);
    end
    if (cmd.m_latch) begin
      cur_hdr <= rd_data;
      nxt     <= AW'(next_walk);
    end
    if (cmd.m_merge) begin
      cur_hdr <= {1'b0, merged_size};
      nxt     <= AW'(next_merged);
    end
    if (cmd.m_shift) begin
      off     <= nxt;
      cur_hdr <= rd_data;
      nxt     <= AW'(next_shift);
    end
    if (cmd.set_st) begin
      st <= cmd.st_code;
    end
    if (cmd.emit) begin
      out_offset <= res;
      out_status <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### sv/ffha_ctrl.sv
// Controller: sequences the header walks, splits, frees and merges.
module ffha_ctrl import ffha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_MRD0  = 4'd5;
  localparam logic [3:0] S_MEV0  = 4'd6;
  localparam logic [3:0] S_MRDN  = 4'd7;
  localparam logic [3:0] S_MEVN  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_cmd == CMD_ALLOC && stat.bad_size) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_BAD_SIZE;
            state_next  = S_FIN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_off = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.is_free) begin
          if (stat.fit) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_OK;
            if (stat.split) begin
              cmd.wr_low = 1'b1;
              state_next = S_SPLIT;
            end else begin
              cmd.wr_whole = 1'b1;
              state_next   = S_FIN;
            end
          end else if (stat.walk_end) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NO_SPACE;
            state_next  = S_FIN;
          end else begin
            cmd.walk_step = 1'b1;
            state_next    = S_RD;
          end
        end else if (stat.ptr_hit) begin
          cmd.set_st = 1'b1;
          if (stat.used) begin
            cmd.wr_clear = 1'b1;
            cmd.zero_off = 1'b1;
            cmd.st_code  = ST_OK;
            state_next   = S_MRD0;
          end else begin
            cmd.st_code = ST_REDUNDANT;
            state_next  = S_FIN;
          end
        end else if (stat.walk_end) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_BAD_PTR;
          state_next  = S_FIN;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_RD;
        end
      end
      S_SPLIT: begin
        cmd.wr_high = 1'b1;
        state_next  = S_FIN;
      end
      S_MRD0: begin
        cmd.rd_off = 1'b1;
        state_next = S_MEV0;
      end
      S_MEV0: begin
        cmd.m_latch = 1'b1;
        state_next  = stat.walk_end ? S_FIN : S_MRDN;
      end
      S_MRDN: begin
        cmd.rd_nxt = 1'b1;
        state_next = S_MEVN;
      end
      S_MEVN: begin
        if (stat.both_free) begin
          cmd.m_merge = 1'b1;
          state_next  = stat.merged_end ? S_FIN : S_MRDN;
        end else begin
          cmd.m_shift = 1'b1;
          state_next  = stat.shift_end ? S_FIN : S_MRDN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator.
//
//  channel  | dir | tdata (low bit up)                       | tuser
//  s_axis   | in  | request_size[15:0], payload_offset[27:16] | cmd
//  m_axis   | out | result_offset[11:0], status[14:12]        | -
//
// One command at a time. Each header visited takes a registered memory
// read, then an evaluate step; a successful free adds a full merge walk
// of the headers from offset 0. After reset the S_INIT state writes the
// initial free header, then s_axis_tready rises. A stalled m_axis beat
// holds; the next command is taken meanwhile and waits only at its own
// result.
`include "assert_macros.svh"

module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // request_size, payload_offset, zero pad
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // result_offset, status, zero pad
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [11:0] out_offset;
  logic [2:0]  out_status;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (s_axis_tuser),
    .in_req     (s_axis_tdata[15:0]),
    .in_ptr     (s_axis_tdata[27:16]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_offset (out_offset),
    .out_status (out_status)
  );

  assign m_axis_tdata = {1'b0, out_status, out_offset};

  // status code stays in range
  `ASSERT_ALWAYS(a_status_range, clk, rst, !m_axis_tvalid || out_status <= ST_BAD_PTR)
  // a non-zero offset comes only with success
  `ASSERT_ALWAYS(a_err_zero_off, clk, rst, !m_axis_tvalid || out_status == ST_OK || out_offset == 12'd0)
  // a taken command keeps the input closed in the next cycle
  `ASSERT_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
